/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/sida_pkg.sv */
package sida_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int DIGIT_MAX   = 10;
   localparam int DIGIT_IDX_W = 4;
   localparam int COUNT_W     = 4;
   localparam int OUT_DATA_W  = 16;

   // Divide by ten through a reciprocal multiply, exact for any 32-bit operand.
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam int          PROD_W      = VALUE_WIDTH + 32;
   localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic quot_zero;
      logic negative;
      logic rd_zero;
      logic out_free;
   } status_type;

endpackage

/* rtl/signed_int_to_decimal_ascii.sv */
// Takes one value at a time: req_tready is high only in idle, so a new value is accepted
// only after every character of the last one, up to 11 for 32 bits, has entered the output
// register. The divide-by-ten unit does one reciprocal multiply and one remainder step per
// digit, and the one-character output register holds its character while rsp_tready is low.
// Reset: synchronous, active high; clears the controller and the output valid only.
module signed_int_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] char_code, [11:8] char_total, [15:12] zero
   output logic        rsp_tlast    // is_last
);

   sida_pkg::cmd_type    cmd;
   sida_pkg::status_type status;

   sida_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sida_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .value      (req_tdata[sida_pkg::VALUE_WIDTH-1:0]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/sida_ctrl.sv */
module sida_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sida_pkg::status_type status,
   output sida_pkg::cmd_type    cmd
);

   sida_pkg::state_type state_ff;
   sida_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sida_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sida_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sida_pkg::ST_MUL;
            end
         end
         sida_pkg::ST_MUL: begin
            state_in = sida_pkg::ST_DIV;
         end
         sida_pkg::ST_DIV: begin
            if (!status.quot_zero) begin
               state_in = sida_pkg::ST_MUL;
            end else if (status.negative) begin
               state_in = sida_pkg::ST_SIGN;
            end else begin
               state_in = sida_pkg::ST_DIGIT;
            end
         end
         sida_pkg::ST_SIGN: begin
            if (status.out_free) begin
               state_in = sida_pkg::ST_DIGIT;
            end
         end
         sida_pkg::ST_DIGIT: begin
            if (status.out_free && status.rd_zero) begin
               state_in = sida_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sida_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         sida_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         sida_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         sida_pkg::ST_DIV: begin
            cmd.div = 1'b1;
         end
         sida_pkg::ST_SIGN: begin
            cmd.emit_sign = status.out_free;
         end
         sida_pkg::ST_DIGIT: begin
            cmd.emit_digit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/sida_datapath.sv */
module sida_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [sida_pkg::VALUE_WIDTH-1:0]      value,
   input  sida_pkg::cmd_type                     cmd,
   output sida_pkg::status_type                  status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sida_pkg::OUT_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast
);

   logic [sida_pkg::VALUE_WIDTH-1:0] mag_ff;
   logic                             neg_ff;
   logic [sida_pkg::QUOT_W-1:0]      quot_ff;
   logic [3:0]                       digit_ff [sida_pkg::DIGIT_MAX];
   logic [sida_pkg::COUNT_W-1:0]     ndig_ff;
   logic [sida_pkg::DIGIT_IDX_W-1:0] rd_ff;
   logic                             valid_ff;
   logic [7:0]                       char_ff;
   logic [sida_pkg::COUNT_W-1:0]     total_ff;
   logic                             last_ff;

   logic [sida_pkg::VALUE_WIDTH-1:0] mag_in;
   logic [sida_pkg::PROD_W-1:0]      product;
   logic [3:0]                       quot_ten_lo;
   logic [3:0]                       rem;
   logic [sida_pkg::COUNT_W-1:0]     total;

   assign mag_in      = value[sida_pkg::VALUE_WIDTH-1] ? (~value + 1'b1) : value;
   assign product     = mag_ff * sida_pkg::RECIP_TEN;
   assign quot_ten_lo = {quot_ff[0], 3'b000} + {quot_ff[2:0], 1'b0};
   assign rem         = mag_ff[3:0] - quot_ten_lo;
   assign total       = ndig_ff + {{(sida_pkg::COUNT_W-1){1'b0}}, neg_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff  <= mag_in;
         neg_ff  <= value[sida_pkg::VALUE_WIDTH-1];
         ndig_ff <= '0;
      end
      if (cmd.mul) begin
         quot_ff <= product[sida_pkg::PROD_W-1:sida_pkg::RECIP_SHIFT];
      end
      if (cmd.div) begin
         digit_ff[ndig_ff[sida_pkg::DIGIT_IDX_W-1:0]] <= rem;
         ndig_ff <= ndig_ff + 1'b1;
         rd_ff   <= ndig_ff[sida_pkg::DIGIT_IDX_W-1:0];
         mag_ff  <= {{(sida_pkg::VALUE_WIDTH-sida_pkg::QUOT_W){1'b0}}, quot_ff};
      end
      if (cmd.emit_sign) begin
         char_ff  <= sida_pkg::CHAR_MINUS;
         last_ff  <= 1'b0;
         total_ff <= '0;
      end
      if (cmd.emit_digit) begin
         char_ff  <= sida_pkg::CHAR_ZERO + {4'b0000, digit_ff[rd_ff]};
         last_ff  <= (rd_ff == '0);
         total_ff <= (rd_ff == '0) ? total : '0;
         rd_ff    <= rd_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit_sign || cmd.emit_digit) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   assign status.quot_zero = (quot_ff == '0);
   assign status.negative  = neg_ff;
   assign status.rd_zero   = (rd_ff == '0);
   assign status.out_free  = !valid_ff || rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {{(sida_pkg::OUT_DATA_W-8-sida_pkg::COUNT_W){1'b0}}, total_ff, char_ff};

endmodule

/* rtl/sida_checker.sv */
`include "assert_macros.svh"

module sida_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `ASSERT_IMPLIES(a_mid_total_zero, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[15:8] == 8'h00)
   `ASSERT_IMPLIES(a_last_total, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[15:12] == 4'h0 && rsp_tdata[11:8] != 4'h0 && rsp_tdata[11:8] <= 4'd11)
   `ASSERT_IMPLIES(a_char_code, clock, reset, rsp_tvalid, rsp_tdata[7:0] == 8'h2D || (rsp_tdata[7:0] >= 8'h30 && rsp_tdata[7:0] <= 8'h39))

endmodule

bind signed_int_to_decimal_ascii sida_checker u_checker (.*);
